FILE: sv/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared widths, codes and controller/datapath types of the pattern source.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int TICK_W_DEF      = 32;

  localparam int TIME_W     = 24;
  localparam int DUTY_W     = 7;
  localparam int MODE_W     = 3;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = TIME_W + DUTY_W;
  localparam int THR_W      = TIME_W + 1;
  localparam int DUTY_SCALE = 100;

  // Division of the period-duty product by a hundred: multiply by the
  // rounded-up value of 2^37/100 and keep the bits from 37 up. This is exact
  // for any product below 2^32.
  localparam int                 RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] DUTY_RECIP  = 31'h51EB851F;
  localparam int                 RECIP_SHIFT = 37;
  localparam int                 RPROD_W     = PROD_W + RECIP_W;

  // Item operations
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;

  // Signal modes
  localparam logic [MODE_W-1:0] MODE_LOW    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HIGH   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PULSE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEQ    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POL    = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_THR_GO,
    ST_SQ_WAIT,
    ST_LAST,
    ST_WRAP,
    ST_LOOP_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_e;

  typedef enum logic {
    DIV_SQUARE,
    DIV_LOOP
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     thr_ld;
    logic     rd_en;
    logic     rd_last;
    logic     last_ld;
    logic     lvl_init;
    logic     tt_ld;
    logic     tt_rem;
    logic     scan_clr;
    logic     scan_step;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              period_zero;
    logic              used_zero;
    logic              loop_wrap;
    logic              div_done;
    logic              scan_hit;
    logic              scan_end;
    logic              out_free;
  } status_t;

endpackage

FILE: sv/programmable_signal_pattern_source_top.sv
// ----------------------------------------------------------------------------
// programmable_signal_pattern_source_top
// Tick-driven test-signal source: constant, square, single pulse or table.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  s_axis   in         s_axis_tvalid/tready       tuser op, tdata entry fields
//  m_axis   out        m_axis_tvalid/tready       tdata pin and raw level
//  cfg      in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
//  Constant, pulse and zero-period square items go from acceptance through mode
//  evaluation straight to the result. Square mode runs the one-bit-per-cycle
//  divider once for the count modulo the period. Sequence mode reads the last
//  table entry, runs the divider for the count modulo its time when the time
//  wraps, and scans the entries in use; an empty table goes to the result.
//  A result beat waiting on m_axis holds the next item in its final cycle.
//  Reset is asynchronous and active low; the table contents need no clearing.
// ----------------------------------------------------------------------------
module programmable_signal_pattern_source_top #(
  parameter int TABLE_DEPTH      = pss_pkg::TABLE_DEPTH_DEF,
  parameter int TICK_COUNT_WIDTH = pss_pkg::TICK_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // entry_index[3:0], entry_time[27:4], entry_level[28], entry_count[33:29], zero pad
  input  logic [39:0]                    s_axis_tdata,
  // op[1:0]
  input  logic [pss_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pin_level[0], raw_level[1], zero pad
  output logic [7:0]                     m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pss_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    pin_level;
  logic    raw_level;

  assign cfg_ready_o = 1'b1;

  pss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pss_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TICK_W      (TICK_COUNT_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (s_axis_tuser),
    .entry_index_i (s_axis_tdata[3:0]),
    .entry_time_i  (s_axis_tdata[27:4]),
    .entry_level_i (s_axis_tdata[28]),
    .entry_count_i (s_axis_tdata[33:29]),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .pin_level_o   (pin_level),
    .raw_level_o   (raw_level)
  );

  assign m_axis_tdata = {6'b0, raw_level, pin_level};

endmodule

FILE: sv/pss_div.sv
// ----------------------------------------------------------------------------
// pss_div
// Restoring divider, one quotient bit per cycle, for a time-width divisor.
// ----------------------------------------------------------------------------
module pss_div #(
  parameter int DW = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DW-1:0]              dividend_i,
  input  logic [pss_pkg::TIME_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [pss_pkg::TIME_W-1:0] rem_o
);
  import pss_pkg::*;

  localparam int CNT_W = $clog2(DW) + 1;

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DW-1:0]    quot_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] dvs_q;

  logic [TIME_W:0]   partial;
  logic [TIME_W:0]   diff;
  logic              ge;
  logic [TIME_W-1:0] rem_d;

  always_comb begin
    partial = {rem_q, quot_q[DW-1]};
    diff    = partial - {1'b0, dvs_q};
    ge      = partial >= {1'b0, dvs_q};
    rem_d   = ge ? diff[TIME_W-1:0] : partial[TIME_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DW);
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DW-2:0], ge};
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

`ifndef SYNTHESIS
  a_no_restart_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while still busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held for more than one cycle");
`endif

endmodule

FILE: sv/pss_dpath.sv
// ----------------------------------------------------------------------------
// pss_dpath
// Registers, tick counter, sequence table, divider and result register.
// ----------------------------------------------------------------------------
module pss_dpath #(
  parameter int TABLE_DEPTH = pss_pkg::TABLE_DEPTH_DEF,
  parameter int TICK_W      = pss_pkg::TICK_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [pss_pkg::OP_W-1:0]       op_i,
  input  logic [pss_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [pss_pkg::TIME_W-1:0]     entry_time_i,
  input  logic                           entry_level_i,
  input  logic [pss_pkg::COUNT_W-1:0]    entry_count_i,
  input  pss_pkg::cmd_t                  cmd_i,
  output pss_pkg::status_t               status_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic                           pin_level_o,
  output logic                           raw_level_o
);
  import pss_pkg::*;

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW    = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (TICK_W > PROD_W) ? TICK_W : PROD_W;

  // Configuration registers
  logic [MODE_W-1:0] mode_q;
  logic [TIME_W-1:0] period_q;
  logic [DUTY_W-1:0] duty_q;
  logic [TIME_W-1:0] delay_q;
  logic [TIME_W-1:0] width_q;
  logic              loop_q;
  logic              hold_q;
  logic              pol_q;

  logic [TICK_W-1:0] count_q;
  logic [UW-1:0]     used_q;
  logic [OP_W-1:0]   op_q;

  logic [PROD_W-1:0] prod_q;
  logic [THR_W-1:0]  thr_q;
  logic [CMP_W-1:0]  tt_q;
  logic [TIME_W-1:0] last_time_q;
  logic              last_level_q;
  logic              lvl_q;
  logic [UW-1:0]     scan_q;

  logic [TIME_W:0]   mem [TABLE_DEPTH];
  logic [TIME_W:0]   rd_q;

  logic              m_tvalid_q;
  logic              pin_q;
  logic              raw_q;

  logic              wr_en;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [UW-1:0]     last_idx;
  logic [RPROD_W-1:0] thr_prod;
  logic [CMP_W-1:0]  div_dividend;
  logic [TIME_W-1:0] div_divisor;
  logic              div_done;
  logic [TIME_W-1:0] div_rem;
  logic [CMP_W-1:0]  t_ext;
  logic [TIME_W:0]   pulse_end;
  logic              pulse_hit;
  logic              sq_level;
  logic              direct_level;
  logic              raw_sel;
  logic              out_free;
  logic              scan_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LOW;
      period_q <= TIME_W'(1);
      duty_q   <= DUTY_W'(50);
      delay_q  <= '0;
      width_q  <= TIME_W'(1);
      loop_q   <= 1'b0;
      hold_q   <= 1'b0;
      pol_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_PERIOD: period_q <= cfg_data_i[TIME_W-1:0];
        REG_DUTY:   duty_q   <= cfg_data_i[DUTY_W-1:0];
        REG_DELAY:  delay_q  <= cfg_data_i[TIME_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[TIME_W-1:0];
        REG_LOOP:   loop_q   <= cfg_data_i[0];
        REG_HOLD:   hold_q   <= cfg_data_i[0];
        REG_POL:    pol_q    <= cfg_data_i[0];
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  assign wr_en    = cmd_i.load && (op_i == OP_WRITE) && (int'(entry_index_i) < TABLE_DEPTH);
  assign waddr    = AW'(entry_index_i);
  assign last_idx = used_q - UW'(1);
  assign raddr    = cmd_i.rd_last ? last_idx[AW-1:0] : scan_q[AW-1:0];
  assign out_free = !m_tvalid_q || m_tready_i;
  assign scan_end = scan_q == used_q;

  // The count is cleared by a restart on acceptance and advances only once a
  // tick's level has gone to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      used_q  <= '0;
      scan_q  <= '0;
    end else begin
      if (cmd_i.load && op_i == OP_RESTART) begin
        count_q <= '0;
      end else if (cmd_i.out_ld && op_q == OP_TICK && count_q != '1) begin
        count_q <= count_q + TICK_W'(1);
      end
      if (wr_en) begin
        used_q <= (int'(entry_count_i) > TABLE_DEPTH) ? UW'(TABLE_DEPTH) : UW'(entry_count_i);
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= {entry_level_i, entry_time_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  // The square threshold is the registered product divided by a hundred.
  assign thr_prod = RPROD_W'(prod_q) * RPROD_W'(DUTY_RECIP);

  // Working registers of one item.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(period_q) * PROD_W'(duty_q);
    if (cmd_i.load) begin
      op_q <= op_i;
    end
    if (cmd_i.thr_ld) begin
      thr_q <= thr_prod[RECIP_SHIFT +: THR_W];
    end
    if (cmd_i.last_ld) begin
      last_time_q  <= rd_q[TIME_W-1:0];
      last_level_q <= rd_q[TIME_W];
    end
    if (cmd_i.tt_ld) begin
      tt_q <= cmd_i.tt_rem ? CMP_W'(div_rem) : t_ext;
    end
    if (cmd_i.lvl_init) begin
      lvl_q <= hold_q ? 1'b0 : last_level_q;
    end else if (cmd_i.scan_step) begin
      lvl_q <= rd_q[TIME_W];
    end
  end

  assign t_ext = CMP_W'(count_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SQUARE: begin
        div_dividend = t_ext;
        div_divisor  = period_q;
      end
      DIV_LOOP: begin
        div_dividend = t_ext;
        div_divisor  = last_time_q;
      end
      default: begin
        div_dividend = t_ext;
        div_divisor  = period_q;
      end
    endcase
  end

  pss_div #(
    .DW(CMP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    pulse_end = {1'b0, delay_q} + {1'b0, width_q};
    pulse_hit = (t_ext >= CMP_W'(delay_q)) && (t_ext < CMP_W'(pulse_end));
    sq_level  = {1'b0, div_rem} < thr_q;
    case (mode_q)
      MODE_HIGH:  direct_level = 1'b1;
      MODE_PULSE: direct_level = pulse_hit;
      default:    direct_level = 1'b0;
    endcase
    if (mode_q == MODE_SQUARE && period_q != '0) begin
      raw_sel = sq_level;
    end else if (mode_q == MODE_SEQ && used_q != '0) begin
      raw_sel = lvl_q;
    end else begin
      raw_sel = direct_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      raw_q <= raw_sel;
      pin_q <= raw_sel ^ pol_q;
    end
  end

  assign m_tvalid_o  = m_tvalid_q;
  assign pin_level_o = pin_q;
  assign raw_level_o = raw_q;

  always_comb begin
    status_o.mode        = mode_q;
    status_o.period_zero = period_q == '0;
    status_o.used_zero   = used_q == '0;
    status_o.loop_wrap   = loop_q && (used_q > UW'(1)) && (last_time_q != '0);
    status_o.div_done    = div_done;
    status_o.scan_hit    = CMP_W'(rd_q[TIME_W-1:0]) <= tt_q;
    status_o.scan_end    = scan_end;
    status_o.out_free    = out_free;
  end

`ifndef SYNTHESIS
  a_out_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> out_free)
    else $error("result loaded over a beat not yet taken");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> !scan_end)
    else $error("table scan stepped past the entries in use");
`endif

endmodule

FILE: sv/pss_ctrl.sv
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer for one item: accept, evaluate the mode, drive the datapath.
// ----------------------------------------------------------------------------
module pss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  pss_pkg::status_t status_i,
  output pss_pkg::cmd_t    cmd_o
);
  import pss_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (status_i.mode)
          MODE_SQUARE: begin
            state_d = status_i.period_zero ? ST_DONE : ST_THR_GO;
          end
          MODE_SEQ: begin
            if (status_i.used_zero) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_last = 1'b1;
              state_d       = ST_LAST;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_THR_GO: begin
        // The threshold period*duty/100 is latched while the divider starts
        // on the count modulo the period.
        cmd_o.thr_ld    = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SQUARE;
        state_d         = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_LAST: begin
        cmd_o.last_ld = 1'b1;
        state_d       = ST_WRAP;
      end
      ST_WRAP: begin
        cmd_o.lvl_init = 1'b1;
        if (status_i.loop_wrap) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_LOOP;
          state_d         = ST_LOOP_WAIT;
        end else begin
          cmd_o.tt_ld    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_SCAN_RD;
        end
      end
      ST_LOOP_WAIT: begin
        cmd_o.div_sel = DIV_LOOP;
        if (status_i.div_done) begin
          cmd_o.tt_ld    = 1'b1;
          cmd_o.tt_rem   = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (status_i.scan_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        // The scan stops at the first entry that lies after the current time.
        if (status_i.scan_hit) begin
          cmd_o.scan_step = 1'b1;
          state_d         = ST_SCAN_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: tb/sv/pin_level_checker.sv
// ----------------------------------------------------------------------------
// pin_level_checker
// Watches the item, result and register channels of the pattern source,
// keeps its own copy of the registers, tick count and level table, works out
// the pin and raw level that each accepted item must produce, and compares
// every result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pin_level_checker #(
  parameter int TABLE_DEPTH = pss_pkg::TABLE_DEPTH_DEF,
  parameter int TICK_W      = pss_pkg::TICK_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // entry_index[3:0], entry_time[27:4], entry_level[28], entry_count[33:29], zero pad
  input  logic [39:0]                    s_tdata_i,
  // op[1:0]
  input  logic [pss_pkg::OP_W-1:0]       s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // pin_level[0], raw_level[1], zero pad
  input  logic [7:0]                     m_tdata_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import pss_pkg::*;

  typedef struct packed {
    logic pin;
    logic raw;
  } level_beat_t;

  level_beat_t expected_levels[$];

  logic [MODE_W-1:0]  mode_r;
  logic [TIME_W-1:0]  period_r;
  logic [DUTY_W-1:0]  duty_r;
  logic [TIME_W-1:0]  delay_r;
  logic [TIME_W-1:0]  width_r;
  logic               loop_r;
  logic               hold_r;
  logic               pol_r;

  logic [TICK_W-1:0]  tick_cnt;
  logic [TIME_W-1:0]  seq_time [TABLE_DEPTH];
  logic               seq_lvl  [TABLE_DEPTH];
  logic [COUNT_W-1:0] seq_used;

  int errors;
  int checked;

  assign fail_count_o = errors;
  assign checked_o    = checked;

  // Generated level for the current tick count and settings.
  function automatic logic level_now();
    longint unsigned t;
    longint unsigned p;
    longint unsigned thr;
    longint unsigned pulse_end;
    int unsigned     n;
    int unsigned     i;
    logic            lvl;
    bit              stop;
    t = tick_cnt;
    case (mode_r)
      MODE_HIGH: return 1'b1;
      MODE_SQUARE: begin
        p = period_r;
        if (p == 0) return 1'b0;
        thr = (p * duty_r) / DUTY_SCALE;
        return (t % p) < thr;
      end
      MODE_PULSE: begin
        pulse_end = delay_r;
        pulse_end = pulse_end + width_r;
        return (t >= delay_r) && (t < pulse_end);
      end
      MODE_SEQ: begin
        n = seq_used;
        if (n == 0) return 1'b0;
        if (loop_r && n > 1 && seq_time[n-1] != 0) t = t % seq_time[n-1];
        // Before the first entry the level is either forced low or taken
        // from the last entry in use.
        lvl  = hold_r ? 1'b0 : seq_lvl[n-1];
        stop = 1'b0;
        for (i = 0; i < n; i++) begin
          if (!stop) begin
            if (seq_time[i] <= t) lvl = seq_lvl[i];
            else stop = 1'b1;
          end
        end
        return lvl;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    level_beat_t        want;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] cnt;
    logic               raw;
    if (!rst_ni) begin
      mode_r   = MODE_LOW;
      period_r = 24'd1;
      duty_r   = 7'd50;
      delay_r  = '0;
      width_r  = 24'd1;
      loop_r   = 1'b0;
      hold_r   = 1'b0;
      pol_r    = 1'b0;
      tick_cnt = '0;
      seq_used = '0;
      errors   = 0;
      checked  = 0;
      expected_levels.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:   mode_r   = cfg_data_i[MODE_W-1:0];
          REG_PERIOD: period_r = cfg_data_i[TIME_W-1:0];
          REG_DUTY:   duty_r   = cfg_data_i[DUTY_W-1:0];
          REG_DELAY:  delay_r  = cfg_data_i[TIME_W-1:0];
          REG_WIDTH:  width_r  = cfg_data_i[TIME_W-1:0];
          REG_LOOP:   loop_r   = cfg_data_i[0];
          REG_HOLD:   hold_r   = cfg_data_i[0];
          REG_POL:    pol_r    = cfg_data_i[0];
          default: ;
        endcase
      end

      // Results first: a beat leaving at this edge belongs to an older item.
      if (m_tvalid_i && m_tready_i) begin
        if (expected_levels.size() == 0) begin
          errors++;
          $display("%0t: result beat with no outstanding item, actual pin %0b raw %0b",
                   $time, m_tdata_i[0], m_tdata_i[1]);
        end else begin
          want = expected_levels.pop_front();
          checked++;
          if (m_tdata_i[0] !== want.pin) begin
            errors++;
            $display("%0t: pin_level mismatch, expected %0b, actual %0b",
                     $time, want.pin, m_tdata_i[0]);
          end
          if (m_tdata_i[1] !== want.raw) begin
            errors++;
            $display("%0t: raw_level mismatch, expected %0b, actual %0b",
                     $time, want.raw, m_tdata_i[1]);
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        idx = s_tdata_i[3:0];
        cnt = s_tdata_i[33:29];
        if (s_tuser_i == OP_RESTART) begin
          tick_cnt = '0;
        end else if (s_tuser_i == OP_WRITE && idx < TABLE_DEPTH) begin
          seq_time[idx] = s_tdata_i[27:4];
          seq_lvl[idx]  = s_tdata_i[28];
          seq_used      = (cnt > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : cnt;
        end
        raw      = level_now();
        want.raw = raw;
        want.pin = raw ^ pol_r;
        expected_levels.push_back(want);
        // The count moves on only after a tick has reported, and saturates.
        if (s_tuser_i == OP_TICK && tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
      end
      pending_o <= expected_levels.size();
    end
  end

endmodule

FILE: tb/sv/programmable_signal_pattern_source_top_tb.sv
// ----------------------------------------------------------------------------
// programmable_signal_pattern_source_top_tb
// Drives directed and random tick, restart, table-write and unused-op beats through the
// pattern source in many register settings, with random idle bursts on both
// streams and one long output hold-off; a separate checker predicts each
// level and reports mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module programmable_signal_pattern_source_top_tb;
  import pss_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int ITEMS       = 1500;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = OP_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int fail_count;
  int pending;
  int checked;

  int unsigned items_sent  = 0;
  int unsigned phases      = 0;
  int unsigned cycle_count = 0;
  bit          idle_en     = 1'b1;
  bit          rx_hold_req = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  programmable_signal_pattern_source_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pin_level_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending);
      $display("programmable_signal_pattern_source_top regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [3:0] idx,
                           input logic [23:0] tm, input logic lvl, input logic [4:0] cnt);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, cnt, lvl, tm, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Valid is left high between back-to-back writes and lowered by the caller.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Narrow registers sometimes get junk above their width, which must be dropped.
  function automatic logic [23:0] with_spare_bits(input logic [23:0] v, input int w);
    logic [23:0] junk;
    junk = 24'($urandom) << w;
    if ($urandom_range(0, 7) == 0) return v | junk;
    return v;
  endfunction

  task automatic program_regs(input logic [2:0] md, input logic [23:0] per,
                              input logic [6:0] dty, input logic [23:0] dly,
                              input logic [23:0] wid, input bit lp, input bit hd,
                              input bit pl);
    write_reg(REG_MODE,   with_spare_bits(24'(md), MODE_W));
    write_reg(REG_PERIOD, per);
    write_reg(REG_DUTY,   with_spare_bits(24'(dty), DUTY_W));
    write_reg(REG_DELAY,  dly);
    write_reg(REG_WIDTH,  wid);
    write_reg(REG_LOOP,   with_spare_bits(24'(lp), 1));
    write_reg(REG_HOLD,   with_spare_bits(24'(hd), 1));
    write_reg(REG_POL,    with_spare_bits(24'(pl), 1));
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [2:0]  md;
    logic [23:0] per;
    logic [6:0]  dty;
    logic [23:0] dly;
    logic [23:0] wid;
    logic [23:0] tm;
    logic [4:0]  cnt;
    bit          lp;
    bit          hd;
    bit          pl;
    bit          unsorted;
    int unsigned n;
    int unsigned i;
    int unsigned k;
    int unsigned r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: constant low, tick, unused and restart op codes, all-ones noise on the fields.
    send_item(OP_TICK, 4'hF, 24'hFFFFFF, 1'b1, 5'h1F);
    send_item(OP_TICK, 4'h0, 24'h0, 1'b0, 5'h0);
    send_item(OP_NOP, 4'h0, 24'h0, 1'b0, 5'h0);
    send_item(OP_RESTART, 4'h0, 24'h0, 1'b0, 5'h0);
    drain();

    // Table fill in sequence mode with inverted pin. The first entry starts at
    // time one, so time zero falls before it and takes the last entry's level.
    program_regs(MODE_SEQ, 24'd1, 7'd50, 24'd0, 24'd1, 1'b0, 1'b0, 1'b1);
    send_item(OP_WRITE, 4'd0, 24'd1, 1'b1, 5'd0);
    for (i = 0; i < 16; i++) begin
      tm = (i == 15) ? 24'hFFFFFF : 24'(i * 3 + 1);
      send_item(OP_WRITE, 4'(i), tm, i[0], 5'(i + 1));
    end
    send_item(OP_WRITE, 4'd15, 24'd60, 1'b1, 5'd31);
    send_item(OP_TICK, 4'h0, 24'h0, 1'b0, 5'h0);
    send_item(OP_TICK, 4'h0, 24'h0, 1'b0, 5'h0);
    send_item(OP_TICK, 4'h0, 24'h0, 1'b0, 5'h0);
    send_item(OP_RESTART, 4'h0, 24'h0, 1'b0, 5'h0);

    while (items_sent < ITEMS) begin
      drain();
      if (items_sent + 200 >= ITEMS) idle_en = 1'b0;

      r = $urandom_range(0, 9);
      if (r == 0) md = MODE_LOW;
      else if (r == 1) md = MODE_HIGH;
      else if (r <= 4) md = MODE_SQUARE;
      else if (r <= 6) md = MODE_PULSE;
      else if (r <= 8) md = MODE_SEQ;
      else md = 3'($urandom_range(5, 7));

      r = $urandom_range(0, 9);
      if (r == 0) per = 24'd0;
      else if (r == 1) per = 24'hFFFFFF;
      else if (r == 2) per = 24'd1;
      else per = 24'($urandom_range(2, 40));

      r = $urandom_range(0, 9);
      if (r == 0) dty = 7'd0;
      else if (r == 1) dty = 7'd100;
      else if (r == 2) dty = 7'($urandom_range(101, 127));
      else dty = 7'($urandom_range(0, 100));

      dly = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 30));
      r = $urandom_range(0, 9);
      if (r == 0) wid = 24'd0;
      else if (r == 1) wid = 24'hFFFFFF;
      else wid = 24'($urandom_range(1, 30));

      lp = 1'($urandom);
      hd = 1'($urandom);
      pl = 1'($urandom);
      program_regs(md, per, dty, dly, wid, lp, hd, pl);

      if (md == MODE_SEQ) begin
        r = $urandom_range(0, 9);
        if (r == 0) n = 1;
        else if (r == 1) n = 16;
        else n = $urandom_range(2, 8);
        unsorted = ($urandom_range(0, 7) == 0);
        tm = 24'($urandom_range(0, 3));
        for (i = 0; i < n; i++) begin
          if (unsorted) tm = 24'($urandom_range(0, 40));
          cnt = 5'(n);
          if (n == 16 && $urandom_range(0, 2) == 0) cnt = 5'($urandom_range(17, 31));
          send_item(OP_WRITE, 4'(i), tm, 1'($urandom), cnt);
          if (!unsorted) tm = tm + 24'($urandom_range(0, 8));
        end
      end

      if (phases == 3) rx_hold_req = 1'b1;

      n = $urandom_range(20, 60);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 82) begin
          send_item(OP_TICK, 4'($urandom), 24'($urandom), 1'($urandom), 5'($urandom));
        end else if (r < 88) begin
          send_item(OP_RESTART, 4'($urandom), 24'($urandom), 1'($urandom), 5'($urandom));
        end else if (r < 93) begin
          send_item(OP_NOP, 4'($urandom), 24'($urandom), 1'($urandom), 5'($urandom));
        end else begin
          tm = $urandom_range(0, 1) ? 24'($urandom_range(0, 40)) : 24'($urandom);
          send_item(OP_WRITE, 4'($urandom), tm, 1'($urandom), 5'($urandom));
        end
      end
      phases++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Summary: %0d items over %0d register settings, %0d result beats checked.",
             items_sent, phases + 2, checked);
    $display("Covered constant, square, pulse, table and undefined modes with loop, hold,");
    $display("polarity, stalls on both streams and one long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("programmable_signal_pattern_source_top regression: pass");
    end else begin
      $display("programmable_signal_pattern_source_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pss_pkg.sv
sv/pss_div.sv
sv/pss_dpath.sv
sv/pss_ctrl.sv
sv/programmable_signal_pattern_source_top.sv
tb/sv/pin_level_checker.sv
tb/sv/programmable_signal_pattern_source_top_tb.sv
